// ----- design/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial arithmetic block.
// Holds the transaction structs, operation codes, register map and FSM states.
// No dependencies.
package spa_pkg;

    // Default configuration of the top level
    localparam int MAX_TERMS_DEF = 8;
    localparam int MAX_EXP_DEF   = 255;

    // Field widths
    localparam int COEF_IN_W  = 16;
    localparam int EXP_IN_W   = 8;
    localparam int COEF_OUT_W = 35;
    localparam int EXP_OUT_W  = 9;
    localparam int SUM_W      = EXP_IN_W + 1;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_OPERATION = 1'b0;

    // Operation codes; the unused code acts as a sum
    localparam logic [1:0] OP_SUM = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef struct packed {
        logic                        which_poly;
        logic                        has_term;
        logic signed [COEF_IN_W-1:0] coef_in;
        logic [EXP_IN_W-1:0]         exp_in;
        logic                        last_term;
    } spa_in_t;

    typedef struct packed {
        logic signed [COEF_OUT_W-1:0] coef_out;
        logic [EXP_OUT_W-1:0]         exp_out;
        logic                         term_present;
        logic                         last_out;
    } spa_out_t;

    // One contribution to an accumulator slot
    typedef struct packed {
        logic                         valid;
        logic [SUM_W-1:0]             addr;
        logic signed [COEF_OUT_W-1:0] val;
    } spa_acc_req_t;

    // Control from the sequencer to the term store
    typedef struct packed {
        logic load;
        logic active;
        logic finish;
    } spa_gen_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_SCAN,
        ST_FLUSH
    } spa_state_t;

endpackage

// ----- design/sparse_polynomial_arithmetic.sv -----
// Sparse polynomial add, subtract and multiply: top level.
// Input channel s_*, result channel m_*, APB-style register port.
// Instantiates spa_term_gen and spa_accum; depends on spa_pkg.
//
// Usage: send the first polynomial's terms (which_poly 0), then the second's
// (which_poly 1), each ending with last_term. The transaction that ends the
// second polynomial starts a run: the operation register (0 sum, 1 first
// minus second, 2 product) selects what is accumulated into 2*MAX_EXP+1
// coefficient slots of a single-port-read memory, one contribution per cycle
// (fc*sc contributions for a product, fc+sc otherwise), after which the
// read-modify-write pipe drains. A scan then reads every slot from the
// highest exponent down, one slot per cycle unless the receiver stalls,
// emitting nonzero terms and zeroing each slot behind it; the last term is
// marked with last_out, and an empty result yields one item with
// term_present low. The memory's one read port serves both contributions
// and scan reads. No input is taken during a run. Results sit in an output
// register; while the receiver stalls, the scan holds its current slot and
// waits. After reset the block zeroes every memory slot before s_ready rises.
module sparse_polynomial_arithmetic #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXP   = spa_pkg::MAX_EXP_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  spa_pkg::spa_in_t             s_payload,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output spa_pkg::spa_out_t            m_payload,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spa_pkg::PADDR_W-1:0]  paddr,
    input  logic [spa_pkg::PDATA_W-1:0]  pwdata,
    output logic [spa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int ACC_SLOTS = 2 * MAX_EXP + 1;
    localparam int ACC_AW    = $clog2(ACC_SLOTS);

    spa_pkg::spa_state_t state_reg, state_next;
    logic [1:0]          op_reg;

    logic [ACC_AW-1:0] scan_addr_reg, scan_addr_next;
    logic              scan_left_reg, scan_left_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [ACC_AW-1:0] rd_slot_reg, rd_slot_next;
    logic              pend_valid_reg, pend_valid_next;
    logic signed [spa_pkg::COEF_OUT_W-1:0] pend_coef_reg, pend_coef_next;
    logic [ACC_AW-1:0] pend_exp_reg, pend_exp_next;

    logic              m_valid_reg, m_valid_next;
    spa_pkg::spa_out_t m_data_reg, m_data_next;

    spa_pkg::spa_gen_ctrl_t gen_ctrl;
    spa_pkg::spa_acc_req_t  acc_req;
    logic                   gen_done;
    logic                   rd_en, wz_en, acc_busy;
    logic [ACC_AW-1:0]      wz_addr;
    logic signed [spa_pkg::COEF_OUT_W-1:0] acc_rdata;
    logic                   out_free, data_nz, consume;

    spa_term_gen #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_EXP   (MAX_EXP)
    ) u_term_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (gen_ctrl),
        .in_item   (s_payload),
        .operation (op_reg),
        .req       (acc_req),
        .gen_done  (gen_done)
    );

    spa_accum #(
        .MAX_EXP (MAX_EXP)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (acc_req),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .wz_en   (wz_en),
        .wz_addr (wz_addr),
        .rdata   (acc_rdata),
        .busy    (acc_busy)
    );

    // Register port: operation register only
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == spa_pkg::REG_OPERATION) begin
            prdata = spa_pkg::PDATA_W'(op_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= spa_pkg::OP_SUM;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == spa_pkg::REG_OPERATION)) begin
            op_reg <= pwdata[1:0];
        end
    end

    assign s_ready = (state_reg == spa_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign data_nz  = (acc_rdata != '0);
    assign consume  = (state_reg == spa_pkg::ST_SCAN) && rd_pend_reg &&
                      (!data_nz || !pend_valid_reg || out_free);

    // Sequencer: clear, load, accumulate, scan, flush
    always_comb begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        rd_pend_next    = rd_pend_reg;
        rd_slot_next    = rd_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        gen_ctrl        = '0;
        rd_en           = 1'b0;
        wz_en           = 1'b0;
        wz_addr         = rd_slot_reg;

        unique case (state_reg)
            spa_pkg::ST_CLEAR: begin
                wz_en   = 1'b1;
                wz_addr = scan_addr_reg;
                if (scan_addr_reg == '0) begin
                    state_next = spa_pkg::ST_IDLE;
                end else begin
                    scan_addr_next = scan_addr_reg - 1'b1;
                end
            end
            spa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    gen_ctrl.load = 1'b1;
                    if (s_payload.which_poly && s_payload.last_term) begin
                        state_next = spa_pkg::ST_ACC;
                    end
                end
            end
            spa_pkg::ST_ACC: begin
                gen_ctrl.active = 1'b1;
                if (gen_done && !acc_busy) begin
                    state_next      = spa_pkg::ST_SCAN;
                    scan_addr_next  = ACC_AW'(ACC_SLOTS - 1);
                    scan_left_next  = 1'b1;
                    rd_pend_next    = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            spa_pkg::ST_SCAN: begin
                // Retire the slot in hand: zero it, push the held term if a newer one arrives
                if (consume) begin
                    wz_en        = 1'b1;
                    rd_pend_next = 1'b0;
                    if (data_nz) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{coef_out: pend_coef_reg,
                                             exp_out: spa_pkg::EXP_OUT_W'(pend_exp_reg),
                                             term_present: 1'b1,
                                             last_out: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_coef_next  = acc_rdata;
                        pend_exp_next   = rd_slot_reg;
                    end
                end
                // Advance the read pointer when the data register is free
                if (scan_left_reg && (!rd_pend_reg || consume)) begin
                    rd_en          = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_slot_next   = scan_addr_reg;
                    scan_addr_next = scan_addr_reg - 1'b1;
                    scan_left_next = (scan_addr_reg != '0);
                end
                if (!scan_left_reg && !rd_pend_reg) begin
                    state_next = spa_pkg::ST_FLUSH;
                end
            end
            spa_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = '{coef_out: pend_valid_reg ? pend_coef_reg : '0,
                                        exp_out: pend_valid_reg ?
                                                 spa_pkg::EXP_OUT_W'(pend_exp_reg) : '0,
                                        term_present: pend_valid_reg,
                                        last_out: 1'b1};
                    pend_valid_next = 1'b0;
                    gen_ctrl.finish = 1'b1;
                    state_next      = spa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= spa_pkg::ST_CLEAR;
            scan_addr_reg  <= ACC_AW'(ACC_SLOTS - 1);
            scan_left_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            scan_left_reg  <= scan_left_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        rd_slot_reg   <= rd_slot_next;
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // A presented term always carries a nonzero coefficient
    a_term_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.term_present) |-> (m_data_reg.coef_out != '0))
        else $error("result term with zero coefficient");

    // An empty-result item is always the last of its run
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.term_present) |-> m_data_reg.last_out)
        else $error("empty result item not marked last");

    // The scan only starts once the accumulate pipe has drained
    a_scan_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spa_pkg::ST_SCAN) |-> !acc_busy)
        else $error("scan overlaps an accumulator write");

    // Nonzero terms are found in strictly descending exponent order
    a_scan_descending: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && data_nz && pend_valid_reg) |-> (pend_exp_reg > rd_slot_reg))
        else $error("scan order broken");

endmodule

// ----- design/spa_term_gen.sv -----
// Term store for both operand polynomials and the contribution generator.
// Walks the stored terms and issues one accumulator contribution per cycle.
// Depends on spa_pkg.
module spa_term_gen #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXP   = spa_pkg::MAX_EXP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spa_pkg::spa_gen_ctrl_t ctrl,
    input  spa_pkg::spa_in_t      in_item,
    input  logic [1:0]            operation,
    output spa_pkg::spa_acc_req_t req,
    output logic                  gen_done
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic signed [spa_pkg::COEF_IN_W-1:0] first_coef_reg  [MAX_TERMS];
    logic [spa_pkg::EXP_IN_W-1:0]         first_exp_reg   [MAX_TERMS];
    logic signed [spa_pkg::COEF_IN_W-1:0] second_coef_reg [MAX_TERMS];
    logic [spa_pkg::EXP_IN_W-1:0]         second_exp_reg  [MAX_TERMS];

    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic             first_closed_reg, first_closed_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    logic             exp_ok;
    logic [CNT_W-1:0] first_base;
    logic             first_wr, second_wr;

    logic                                 i_in, j_in, is_mul, gen_valid;
    logic signed [spa_pkg::COEF_IN_W-1:0] f_coef, s_coef;
    logic [spa_pkg::EXP_IN_W-1:0]         f_exp, s_exp;
    logic signed [2*spa_pkg::COEF_IN_W-1:0] prod;
    logic signed [spa_pkg::COEF_OUT_W-1:0]  f_ext, s_ext;

    // Load: decide where an incoming term goes and update counts
    always_comb begin
        exp_ok            = (32'(in_item.exp_in) <= MAX_EXP);
        first_base        = first_closed_reg ? '0 : first_count_reg;
        first_wr          = 1'b0;
        second_wr         = 1'b0;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        first_closed_next = first_closed_reg;
        if (ctrl.finish) begin
            first_count_next  = '0;
            second_count_next = '0;
            first_closed_next = 1'b0;
        end else if (ctrl.load) begin
            if (!in_item.which_poly) begin
                if (in_item.has_term) begin
                    first_wr          = exp_ok && (32'(first_base) < MAX_TERMS);
                    first_count_next  = first_wr ? first_base + 1'b1 : first_base;
                    first_closed_next = 1'b0;
                end
                if (in_item.last_term) begin
                    first_closed_next = 1'b1;
                end
            end else if (in_item.has_term) begin
                second_wr         = exp_ok && (32'(second_count_reg) < MAX_TERMS);
                second_count_next = second_wr ? second_count_reg + 1'b1 : second_count_reg;
            end
        end
    end

    // Hold term payloads; no reset needed
    always_ff @(posedge aclk) begin
        if (first_wr) begin
            first_coef_reg[first_base[IDX_W-1:0]] <= in_item.coef_in;
            first_exp_reg[first_base[IDX_W-1:0]]  <= in_item.exp_in;
        end
        if (second_wr) begin
            second_coef_reg[second_count_reg[IDX_W-1:0]] <= in_item.coef_in;
            second_exp_reg[second_count_reg[IDX_W-1:0]]  <= in_item.exp_in;
        end
    end

    // Select the current pair of terms and form the contribution
    always_comb begin
        f_coef    = first_coef_reg[i_reg[IDX_W-1:0]];
        f_exp     = first_exp_reg[i_reg[IDX_W-1:0]];
        s_coef    = second_coef_reg[j_reg[IDX_W-1:0]];
        s_exp     = second_exp_reg[j_reg[IDX_W-1:0]];
        i_in      = (i_reg < first_count_reg);
        j_in      = (j_reg < second_count_reg);
        is_mul    = (operation == spa_pkg::OP_MUL);
        prod      = (2*spa_pkg::COEF_IN_W)'(f_coef) * (2*spa_pkg::COEF_IN_W)'(s_coef);
        f_ext     = spa_pkg::COEF_OUT_W'(f_coef);
        s_ext     = spa_pkg::COEF_OUT_W'(s_coef);
        gen_valid = is_mul ? (i_in && j_in) : (i_in || j_in);
        req.valid = ctrl.active && gen_valid;
        if (is_mul) begin
            req.addr = spa_pkg::SUM_W'(f_exp) + spa_pkg::SUM_W'(s_exp);
            req.val  = spa_pkg::COEF_OUT_W'(prod);
        end else if (i_in) begin
            req.addr = spa_pkg::SUM_W'(f_exp);
            req.val  = f_ext;
        end else begin
            req.addr = spa_pkg::SUM_W'(s_exp);
            req.val  = (operation == spa_pkg::OP_SUB) ? -s_ext : s_ext;
        end
        gen_done = !gen_valid;
    end

    // Advance the pair counters; restart them on every load
    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        if (ctrl.load) begin
            i_next = '0;
            j_next = '0;
        end else if (ctrl.active && gen_valid) begin
            if (is_mul) begin
                if (j_reg + 1'b1 < second_count_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end
            end else if (i_in) begin
                i_next = i_reg + 1'b1;
            end else begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_closed_reg <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
        end else begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_closed_reg <= first_closed_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
        end
    end

endmodule

// ----- design/spa_accum.sv -----
// Accumulator memory with a read-modify-write pipeline and write forwarding.
// Also serves scan reads and zero writes for clearing.
// Depends on spa_pkg.
module spa_accum #(
    parameter int MAX_EXP = spa_pkg::MAX_EXP_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  spa_pkg::spa_acc_req_t                 req,
    input  logic                                  rd_en,
    input  logic [$clog2(2*MAX_EXP+1)-1:0]        rd_addr,
    input  logic                                  wz_en,
    input  logic [$clog2(2*MAX_EXP+1)-1:0]        wz_addr,
    output logic signed [spa_pkg::COEF_OUT_W-1:0] rdata,
    output logic                                  busy
);

    localparam int ACC_SLOTS = 2 * MAX_EXP + 1;
    localparam int ACC_AW    = $clog2(ACC_SLOTS);

    logic signed [spa_pkg::COEF_OUT_W-1:0] acc_mem [ACC_SLOTS];
    logic signed [spa_pkg::COEF_OUT_W-1:0] rdata_reg;

    logic                                  p1_valid_reg;
    logic [ACC_AW-1:0]                     p1_addr_reg;
    logic signed [spa_pkg::COEF_OUT_W-1:0] p1_val_reg;
    logic                                  wb_valid_reg;
    logic [ACC_AW-1:0]                     wb_addr_reg;
    logic signed [spa_pkg::COEF_OUT_W-1:0] wb_data_reg;

    logic                                  ren, wen;
    logic [ACC_AW-1:0]                     raddr, waddr;
    logic signed [spa_pkg::COEF_OUT_W-1:0] operand, sum, wdata;

    // Port selection: contributions take the read port, the pipeline the write port
    always_comb begin
        ren     = req.valid || rd_en;
        raddr   = req.valid ? ACC_AW'(req.addr) : rd_addr;
        operand = (wb_valid_reg && (wb_addr_reg == p1_addr_reg)) ? wb_data_reg : rdata_reg;
        sum     = operand + p1_val_reg;
        wen     = p1_valid_reg || wz_en;
        waddr   = p1_valid_reg ? p1_addr_reg : wz_addr;
        wdata   = p1_valid_reg ? sum : '0;
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata_reg <= acc_mem[raddr];
        end
        if (wen) begin
            acc_mem[waddr] <= wdata;
        end
    end

    // Stage the contribution while its slot is read; keep the last write for forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= req.valid;
            wb_valid_reg <= p1_valid_reg;
        end
        p1_addr_reg <= ACC_AW'(req.addr);
        p1_val_reg  <= req.val;
        wb_addr_reg <= p1_addr_reg;
        wb_data_reg <= sum;
    end

    assign rdata = rdata_reg;
    assign busy  = p1_valid_reg;

endmodule

// ----- bench/spa_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sparse polynomial arithmetic block: watches the input, result
// and register channels, predicts each run's terms and compares them in order.
// Depends on spa_pkg.
module spa_checker #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXP   = spa_pkg::MAX_EXP_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  spa_pkg::spa_in_t            s_payload,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  spa_pkg::spa_out_t           m_payload,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [spa_pkg::PADDR_W-1:0] paddr,
    input  logic [spa_pkg::PDATA_W-1:0] pwdata,
    output int                          mismatches,
    output int                          outstanding
);

    localparam int SLOTS       = 2 * MAX_EXP + 1;
    localparam int MAX_RESULTS = 64;

    // Shadow copy of the block's term stores and operation register
    logic signed [spa_pkg::COEF_IN_W-1:0]  first_coef  [MAX_TERMS];
    logic [spa_pkg::EXP_IN_W-1:0]          first_exp   [MAX_TERMS];
    logic signed [spa_pkg::COEF_IN_W-1:0]  second_coef [MAX_TERMS];
    logic [spa_pkg::EXP_IN_W-1:0]          second_exp  [MAX_TERMS];
    int                                    first_cnt;
    int                                    second_cnt;
    bit                                    first_done;
    logic [1:0]                            op_reg;
    logic signed [spa_pkg::COEF_OUT_W-1:0] slot_acc [SLOTS];

    spa_pkg::spa_out_t result_terms_q [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch @ %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Accumulate the selected combination, then queue the nonzero terms from the
    // highest exponent down; an empty result becomes a single bare last item.
    task automatic combine_polynomials();
        int i;
        int j;
        int k;
        int e;
        int n;
        bit have_held;
        spa_pkg::spa_out_t held;
        logic signed [spa_pkg::COEF_OUT_W-1:0] prod;
        for (k = 0; k < SLOTS; k++) slot_acc[k] = '0;
        if (op_reg == spa_pkg::OP_MUL) begin
            for (i = 0; i < first_cnt; i++) begin
                for (j = 0; j < second_cnt; j++) begin
                    e = first_exp[i] + second_exp[j];
                    prod = first_coef[i] * second_coef[j];
                    if (e < SLOTS) slot_acc[e] = slot_acc[e] + prod;
                end
            end
        end else begin
            for (i = 0; i < first_cnt; i++) begin
                slot_acc[first_exp[i]] = slot_acc[first_exp[i]] + first_coef[i];
            end
            for (j = 0; j < second_cnt; j++) begin
                if (op_reg == spa_pkg::OP_SUB) begin
                    slot_acc[second_exp[j]] = slot_acc[second_exp[j]] - second_coef[j];
                end else begin
                    slot_acc[second_exp[j]] = slot_acc[second_exp[j]] + second_coef[j];
                end
            end
        end
        // hold each term back one step so the final one can be marked
        n = 0;
        have_held = 1'b0;
        held = '0;
        for (k = SLOTS - 1; k >= 0; k--) begin
            if (slot_acc[k] != 0 && n < MAX_RESULTS) begin
                if (have_held) result_terms_q.push_back(held);
                held.coef_out     = slot_acc[k];
                held.exp_out      = k[spa_pkg::EXP_OUT_W-1:0];
                held.term_present = 1'b1;
                held.last_out     = 1'b0;
                have_held = 1'b1;
                n++;
            end
        end
        held.last_out = 1'b1;
        result_terms_q.push_back(held);
        first_cnt  = 0;
        second_cnt = 0;
        first_done = 1'b0;
    endtask

    always @(posedge aclk) begin : watch
        spa_pkg::spa_out_t want;
        spa_pkg::spa_in_t  item;
        if (!aresetn) begin
            first_cnt  = 0;
            second_cnt = 0;
            first_done = 1'b0;
            op_reg     = spa_pkg::OP_SUM;
            mismatches = 0;
            result_terms_q.delete();
            outstanding <= 0;
        end else begin
            // follow register writes
            if (psel && penable && pwrite && pready &&
                    paddr[2] == spa_pkg::REG_OPERATION) begin
                op_reg = pwdata[1:0];
            end

            // compare each result transaction with the oldest expected term
            if (m_valid && m_ready) begin
                if (result_terms_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: coef %0d exp %0d",
                                              m_payload.coef_out, m_payload.exp_out));
                end else begin
                    want = result_terms_q.pop_front();
                    if (m_payload.coef_out !== want.coef_out)
                        report_mismatch($sformatf("coef_out %0d, expected %0d",
                                                  m_payload.coef_out, want.coef_out));
                    if (m_payload.exp_out !== want.exp_out)
                        report_mismatch($sformatf("exp_out %0d, expected %0d",
                                                  m_payload.exp_out, want.exp_out));
                    if (m_payload.term_present !== want.term_present)
                        report_mismatch($sformatf("term_present %0b, expected %0b",
                                                  m_payload.term_present, want.term_present));
                    if (m_payload.last_out !== want.last_out)
                        report_mismatch($sformatf("last_out %0b, expected %0b",
                                                  m_payload.last_out, want.last_out));
                end
            end

            // absorb an input transaction into the shadow stores
            if (s_valid && s_ready) begin
                item = s_payload;
                if (!item.which_poly) begin
                    if (item.has_term) begin
                        // a term after the first polynomial closed starts it over
                        if (first_done) begin
                            first_cnt  = 0;
                            first_done = 1'b0;
                        end
                        if (int'(item.exp_in) <= MAX_EXP && first_cnt < MAX_TERMS) begin
                            first_coef[first_cnt] = item.coef_in;
                            first_exp[first_cnt]  = item.exp_in;
                            first_cnt++;
                        end
                    end
                    if (item.last_term) first_done = 1'b1;
                end else begin
                    if (item.has_term && int'(item.exp_in) <= MAX_EXP
                            && second_cnt < MAX_TERMS) begin
                        second_coef[second_cnt] = item.coef_in;
                        second_exp[second_cnt]  = item.exp_in;
                        second_cnt++;
                    end
                    if (item.last_term) combine_polynomials();
                end
            end
            outstanding <= result_terms_q.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sparse polynomial arithmetic bench: clock, reset, stimulus,
// handshake idling and the verdict. Depends on spa_pkg, the block and spa_checker.
module testbench;

    localparam int MAX_TERMS    = spa_pkg::MAX_TERMS_DEF;
    localparam int MAX_EXP      = spa_pkg::MAX_EXP_DEF;
    localparam int SETTLE_CYCLES = 64 + 2 * MAX_EXP + 40;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_ITEMS  = 8;
    localparam int PHASES       = 8;
    localparam logic [spa_pkg::PADDR_W-1:0] OPERATION_ADDR =
        spa_pkg::PADDR_W'(4 * spa_pkg::REG_OPERATION);
    // the spare operation code falls back to a sum
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic FIRST  = 1'b0;
    localparam logic SECOND = 1'b1;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    spa_pkg::spa_in_t            s_payload = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    spa_pkg::spa_out_t           m_payload;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [spa_pkg::PADDR_W-1:0] paddr     = '0;
    logic [spa_pkg::PDATA_W-1:0] pwdata    = '0;
    logic [spa_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    int         mismatches;
    int         outstanding;
    int         items_sent = 0;
    logic [1:0] idle_mode  = 2'b00;   // bit 0: sender gaps, bit 1: receiver stalls
    bit         hold_req   = 1'b0;

    always #4 aclk = ~aclk;

    sparse_polynomial_arithmetic u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    spa_checker #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_EXP   (MAX_EXP)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Idle share in percent: lighter when both sides idle at once
    function automatic int idle_pct();
        return (idle_mode == 2'b11) ? 23 : 47;
    endfunction

    // Receiver: honor a long hold-off when asked, otherwise stall at random
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (idle_mode[1]) begin
                m_ready <= ($urandom_range(99) >= idle_pct());
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hold the transaction until accepted, then, with sender gaps on, idle at random
    task automatic send_item(input logic which, input logic has,
                             input logic signed [spa_pkg::COEF_IN_W-1:0] coef,
                             input logic [spa_pkg::EXP_IN_W-1:0] e, input logic last);
        spa_pkg::spa_in_t item;
        item.which_poly = which;
        item.has_term   = has;
        item.coef_in    = coef;
        item.exp_in     = e;
        item.last_term  = last;
        s_payload <= item;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (has || last) items_sent++;
        if (idle_mode[0]) begin
            while ($urandom_range(99) < idle_pct()) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    function automatic logic signed [spa_pkg::COEF_IN_W-1:0] random_coef(input bit messy);
        logic signed [spa_pkg::COEF_IN_W-1:0] c;
        case ($urandom_range(9))
            0: c = 16'sh8000;
            1: c = 16'sh7fff;
            2: c = messy ? 16'sh0000 : -16'sd1;
            default: begin
                c = spa_pkg::COEF_IN_W'($urandom);
                if (c == 0) c = 16'sd1;
            end
        endcase
        return c;
    endfunction

    // One polynomial: descending exponents, ended on its last term or by a bare
    // end mark; a messy one may be too long, out of order or carry stray items
    task automatic send_poly(input logic which, input bit messy);
        int n;
        int k;
        int hi;
        int lo;
        int e;
        bit end_only;
        n = messy ? $urandom_range(MAX_TERMS + 2, 4) : $urandom_range(MAX_TERMS);
        end_only = (n == 0) || ($urandom_range(3) == 0);
        hi = 2 ** spa_pkg::EXP_IN_W - 1;
        for (k = 0; k < n; k++) begin
            lo = n - 1 - k;
            if ((messy && $urandom_range(3) == 0) || hi < lo) begin
                e = $urandom_range(2 ** spa_pkg::EXP_IN_W - 1);
            end else begin
                e = $urandom_range(hi, lo);
            end
            if (messy && $urandom_range(5) == 0) begin
                send_item(1'($urandom), 1'b0, random_coef(messy),
                          spa_pkg::EXP_IN_W'($urandom), 1'b0);
            end
            send_item(which, 1'b1, random_coef(messy), e[spa_pkg::EXP_IN_W-1:0],
                      !end_only && k == n - 1);
            hi = e - 1;
        end
        if (end_only) begin
            send_item(which, 1'b0, random_coef(messy), spa_pkg::EXP_IN_W'($urandom), 1'b1);
        end
    endtask

    task automatic send_pair();
        bit messy;
        messy = ($urandom_range(99) < 25);
        // sometimes load a first polynomial that the next one replaces
        if (messy && $urandom_range(2) == 0) send_poly(FIRST, messy);
        send_poly(FIRST, messy);
        send_poly(SECOND, messy);
    endtask

    task automatic write_reg(input logic [spa_pkg::PADDR_W-1:0] addr,
                             input logic [spa_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop the input, then wait out every expected result plus one full scan
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_operation(input logic [1:0] op);
        settle();
        write_reg(OPERATION_ADDR, spa_pkg::PDATA_W'(op));
    endtask

    initial begin
        logic [1:0] op_plan [PHASES];
        int ph;
        int start;
        op_plan = '{spa_pkg::OP_SUM, spa_pkg::OP_SUB, spa_pkg::OP_MUL, OP_SPARE,
                    spa_pkg::OP_MUL, spa_pkg::OP_SUB, spa_pkg::OP_SUM, spa_pkg::OP_MUL};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // the block clears its slots before it takes input
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        write_reg(OPERATION_ADDR, spa_pkg::PDATA_W'(spa_pkg::OP_SUM));

        // sum: extreme coefficients and exponents, top terms cancel, zero coefficient
        send_item(FIRST,  1'b1, 16'sh7fff, 8'd255, 1'b0);
        send_item(FIRST,  1'b1, 16'sh8000, 8'd0,   1'b1);
        send_item(SECOND, 1'b1, -16'sd32767, 8'd255, 1'b0);
        send_item(SECOND, 1'b1, 16'sd0,    8'd7,   1'b0);
        send_item(SECOND, 1'b1, 16'sh8000, 8'd0,   1'b0);
        send_item(SECOND, 1'b0, 16'sd0,    8'd0,   1'b1);

        // empty result from two bare end marks, with stray items between
        send_item(FIRST,  1'b0, 16'sh7fff, 8'd255, 1'b0);
        send_item(FIRST,  1'b0, 16'sd0,    8'd0,   1'b1);
        send_item(SECOND, 1'b0, 16'sh8000, 8'd128, 1'b0);
        send_item(SECOND, 1'b0, 16'sd0,    8'd0,   1'b1);

        // difference: reload of the first polynomial, repeated and rising exponents
        set_operation(spa_pkg::OP_SUB);
        send_item(FIRST,  1'b1, 16'sd5,   8'd10,  1'b0);
        send_item(FIRST,  1'b1, 16'sd5,   8'd10,  1'b0);
        send_item(FIRST,  1'b1, -16'sd3,  8'd3,   1'b1);
        send_item(FIRST,  1'b1, 16'sd7,   8'd200, 1'b1);
        send_item(SECOND, 1'b1, 16'sd2,   8'd100, 1'b0);
        send_item(SECOND, 1'b1, 16'sd3,   8'd100, 1'b0);
        send_item(SECOND, 1'b1, 16'sd1,   8'd101, 1'b1);

        // product at the coefficient and exponent extremes
        set_operation(spa_pkg::OP_MUL);
        send_item(FIRST,  1'b1, 16'sh8000, 8'd255, 1'b0);
        send_item(FIRST,  1'b1, 16'sh7fff, 8'd0,   1'b1);
        send_item(SECOND, 1'b1, 16'sh8000, 8'd255, 1'b0);
        send_item(SECOND, 1'b1, 16'sd1,    8'd1,   1'b1);

        // spare operation code
        set_operation(OP_SPARE);
        send_item(FIRST,  1'b1, 16'sd1, 8'd1, 1'b1);
        send_item(SECOND, 1'b1, 16'sd1, 8'd1, 1'b1);

        // random pairs across operations and idling patterns
        for (ph = 0; ph < PHASES; ph++) begin
            set_operation(op_plan[ph]);
            idle_mode = 2'(ph % 4);
            // starve the result side so the block backs up into its input
            if (ph == 4) hold_req = 1'b1;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_pair();
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS sparse_polynomial_arithmetic");
        end else begin
            $display("FAIL sparse_polynomial_arithmetic");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #4_000_000;
        $display("FAIL sparse_polynomial_arithmetic");
        $finish;
    end

endmodule
